// ===== hw/rtl/pnrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrf_pkg
// shared types and fixed constants of the packed nibble rectangle fill block
// ----------------------------------------------------------------------------
package pnrf_pkg;

    localparam int COORD_IN_W  = 12;
    localparam int COORD_W     = 11;
    localparam int BX_W        = 10;
    localparam int COLOUR_W    = 4;
    localparam int IN_ADDR_W   = 18;
    localparam int BYTE_W      = 8;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic ACT_FILL = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic                  is_read;
        logic [COORD_W-1:0]    x0;
        logic [COORD_W-1:0]    x1;
        logic [COORD_W-1:0]    y0;
        logic [COORD_W-1:0]    y1;
        logic [COLOUR_W-1:0]   colour;
        logic [IN_ADDR_W-1:0]  addr;
        logic                  addr_ok;
    } cmd_t;

endpackage

// ===== hw/rtl/pnrf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrf_front
// accepts items, clamps and orders the corners, checks the read address and
// hands one command per item to the queue
// ----------------------------------------------------------------------------
module pnrf_front #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pnrf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            clear_done,
    input  logic                            q_full,
    output logic                            q_push,
    output pnrf_pkg::cmd_t                  q_cmd
);

    localparam int ROW_BYTES   = (FRAME_WIDTH + 1) / 2;
    localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;

    logic           stage_valid_reg;
    logic           stage_valid_next;
    pnrf_pkg::cmd_t stage_cmd_reg;
    pnrf_pkg::cmd_t in_cmd;
    logic           accept;

    logic [pnrf_pkg::COORD_W-1:0] xa;
    logic [pnrf_pkg::COORD_W-1:0] xb;
    logic [pnrf_pkg::COORD_W-1:0] ya;
    logic [pnrf_pkg::COORD_W-1:0] yb;

    function automatic logic [pnrf_pkg::COORD_W-1:0] clamp_coord(
        input logic [pnrf_pkg::COORD_IN_W-1:0] v,
        input logic [pnrf_pkg::COORD_IN_W-1:0] lim
    );
        logic [pnrf_pkg::COORD_IN_W-1:0] top;
        top = lim - pnrf_pkg::COORD_IN_W'(1);
        if (v[pnrf_pkg::COORD_IN_W-1])
            return '0;
        else if (v >= lim)
            return top[pnrf_pkg::COORD_W-1:0];
        else
            return v[pnrf_pkg::COORD_W-1:0];
    endfunction

    assign xa = clamp_coord(s_tdata[11:0],  pnrf_pkg::COORD_IN_W'(FRAME_WIDTH));
    assign ya = clamp_coord(s_tdata[23:12], pnrf_pkg::COORD_IN_W'(FRAME_HEIGHT));
    assign xb = clamp_coord(s_tdata[35:24], pnrf_pkg::COORD_IN_W'(FRAME_WIDTH));
    assign yb = clamp_coord(s_tdata[47:36], pnrf_pkg::COORD_IN_W'(FRAME_HEIGHT));

    always_comb
    begin
        in_cmd.is_read = (s_tuser == pnrf_pkg::ACT_READ);
        in_cmd.x0      = (xb < xa) ? xb : xa;
        in_cmd.x1      = (xb < xa) ? xa : xb;
        in_cmd.y0      = (yb < ya) ? yb : ya;
        in_cmd.y1      = (yb < ya) ? ya : yb;
        in_cmd.colour  = s_tdata[51:48];
        in_cmd.addr    = s_tdata[69:52];
        in_cmd.addr_ok = (32'(s_tdata[69:52]) < 32'(STORE_BYTES));
    end

    assign q_push   = stage_valid_reg && !q_full;
    assign s_tready = clear_done && (!stage_valid_reg || !q_full);
    assign accept   = s_tvalid && s_tready;
    assign q_cmd    = stage_cmd_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (q_push)
            stage_valid_next = 1'b0;
        if (accept)
            stage_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_cmd_reg <= in_cmd;
    end

endmodule

// ===== hw/rtl/pnrf_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrf_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module pnrf_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pnrf_pkg::cmd_t push_cmd,
    input  logic           pop,
    output pnrf_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    pnrf_pkg::cmd_t                slot_reg [pnrf_pkg::QUEUE_DEPTH];
    logic [pnrf_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [pnrf_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [pnrf_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [pnrf_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [pnrf_pkg::QPTR_W:0]     count_reg;
    logic [pnrf_pkg::QPTR_W:0]     count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (pnrf_pkg::QPTR_W + 1)'(pnrf_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== hw/rtl/pnrf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrf_back
// frame memory with clearing pass, rectangle fill sequencer and read path
// ----------------------------------------------------------------------------
module pnrf_back #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pnrf_pkg::cmd_t                  q_head,
    input  logic                            q_empty,
    output logic                            q_pop,
    output logic                            clear_done,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pnrf_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int ROW_BYTES   = (FRAME_WIDTH + 1) / 2;
    localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_MERGE  = 3'd4;

    logic [pnrf_pkg::BYTE_W-1:0] frame_mem [STORE_BYTES];

    logic [2:0]                     state_reg,    state_next;
    logic [AW-1:0]                  clr_addr_reg, clr_addr_next;
    logic [AW-1:0]                  row_base_reg, row_base_next;
    logic [pnrf_pkg::BX_W-1:0]      bx_reg,       bx_next;
    logic [pnrf_pkg::BX_W-1:0]      bx_first_reg, bx_first_next;
    logic [pnrf_pkg::BX_W-1:0]      bx_last_reg,  bx_last_next;
    logic [pnrf_pkg::COORD_W-1:0]   x0_reg,       x0_next;
    logic [pnrf_pkg::COORD_W-1:0]   x1_reg,       x1_next;
    logic [pnrf_pkg::COORD_W-1:0]   y_reg,        y_next;
    logic [pnrf_pkg::COORD_W-1:0]   y_last_reg,   y_last_next;
    logic [pnrf_pkg::COLOUR_W-1:0]  colour_reg,   colour_next;
    logic                           hi_half_reg,  hi_half_next;
    logic                           rd_ok_reg,    rd_ok_next;
    logic                           out_valid_reg, out_valid_next;
    logic [pnrf_pkg::BYTE_W-1:0]    out_data_reg,  out_data_next;
    logic [pnrf_pkg::BYTE_W-1:0]    rd_data_reg;

    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [pnrf_pkg::BYTE_W-1:0]    wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  cur_addr;
    logic                           lo_on;
    logic                           hi_on;
    logic                           adv;

    assign cur_addr   = row_base_reg + AW'(bx_reg);
    assign lo_on      = ({bx_reg, 1'b0} >= x0_reg);
    assign hi_on      = ({bx_reg, 1'b1} <= x1_reg);
    assign clear_done = (state_reg != ST_CLEAR);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        row_base_next  = row_base_reg;
        bx_next        = bx_reg;
        bx_first_next  = bx_first_reg;
        bx_last_next   = bx_last_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y_next         = y_reg;
        y_last_next    = y_last_reg;
        colour_next    = colour_reg;
        hi_half_next   = hi_half_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_addr;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = cur_addr;
        q_pop          = 1'b0;
        adv            = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == AW'(STORE_BYTES - 1))
                    state_next = ST_IDLE;
                else
                    clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.is_read)
                    begin
                        // one result slot, so a read waits for it to drain
                        if (!out_valid_reg)
                        begin
                            q_pop      = 1'b1;
                            rd_en      = q_head.addr_ok;
                            rd_addr    = AW'(q_head.addr);
                            rd_ok_next = q_head.addr_ok;
                            state_next = ST_RDWAIT;
                        end
                    end
                    else
                    begin
                        q_pop         = 1'b1;
                        x0_next       = q_head.x0;
                        x1_next       = q_head.x1;
                        y_next        = q_head.y0;
                        y_last_next   = q_head.y1;
                        colour_next   = q_head.colour;
                        bx_next       = q_head.x0[pnrf_pkg::COORD_W-1:1];
                        bx_first_next = q_head.x0[pnrf_pkg::COORD_W-1:1];
                        bx_last_next  = q_head.x1[pnrf_pkg::COORD_W-1:1];
                        row_base_next = AW'(32'(q_head.y0) * 32'(ROW_BYTES));
                        state_next    = ST_FILL;
                    end
                end
            end
            ST_RDWAIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_ok_reg ? rd_data_reg : '0;
                state_next     = ST_IDLE;
            end
            ST_FILL:
            begin
                if (lo_on && hi_on)
                begin
                    wr_en   = 1'b1;
                    wr_data = {colour_reg, colour_reg};
                    adv     = 1'b1;
                end
                else
                begin
                    // edge byte: fetch it, keep the other nibble
                    rd_en        = 1'b1;
                    hi_half_next = hi_on;
                    state_next   = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                wr_en      = 1'b1;
                wr_data    = hi_half_reg ? {colour_reg, rd_data_reg[3:0]}
                                         : {rd_data_reg[7:4], colour_reg};
                adv        = 1'b1;
                state_next = ST_FILL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv)
        begin
            if (bx_reg == bx_last_reg)
            begin
                if (y_reg == y_last_reg)
                    state_next = ST_IDLE;
                else
                begin
                    y_next        = y_reg + 1'b1;
                    row_base_next = row_base_reg + AW'(ROW_BYTES);
                    bx_next       = bx_first_reg;
                end
            end
            else
                bx_next = bx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_base_reg <= row_base_next;
        bx_reg       <= bx_next;
        bx_first_reg <= bx_first_next;
        bx_last_reg  <= bx_last_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y_reg        <= y_next;
        y_last_reg   <= y_last_next;
        colour_reg   <= colour_next;
        hi_half_reg  <= hi_half_next;
        rd_ok_reg    <= rd_ok_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= frame_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/packed_nibble_rectangle_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_nibble_rectangle_fill
// 4-bit-per-pixel framebuffer with clamped rectangle fill and byte readback
//
// channel  dir  tdata                                        tuser
// s_*      in   corner_a_x, corner_a_y, corner_b_x,          action
//               corner_b_y, colour_index, read_address
// m_*      out  read_byte                                    -
//
// after reset a clearing pass writes zero to every byte, one per cycle,
// (FRAME_WIDTH+1)/2 * FRAME_HEIGHT bytes in all; s_tready stays low meanwhile
// a fill writes whole bytes directly and edge bytes by read then write,
// row after row, bound by the single memory write port
// m_tvalid is registered, set in ST_RDWAIT after the memory read in ST_IDLE
// a four-entry queue lets the front keep accepting while the back works
// ----------------------------------------------------------------------------
module packed_nibble_rectangle_fill #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // corner_a_x, corner_a_y, corner_b_x, corner_b_y, colour_index,
    // read_address, zero pad
    input  logic [pnrf_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_byte
    output logic [pnrf_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic           clear_done;
    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    logic           q_full;
    pnrf_pkg::cmd_t q_cmd;
    pnrf_pkg::cmd_t q_head;

    pnrf_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clear_done (clear_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    pnrf_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    pnrf_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !q_pop && !m_tvalid)
        else $error("back active during clearing pass");

endmodule
